[rtl/brfp_pkg.sv]
// Package for the byte ring FIFO with peek: data width, operation and status codes.
`default_nettype none
package brfp_pkg;

  localparam int DATA_W = 8;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_REWIND = 3'd3,
    OP_COMMIT = 3'd4,
    OP_SETOFF = 3'd5,
    OP_STATUS = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NO_PEEK = 2'd3
  } status_t;

endpackage
`default_nettype wire

[rtl/brfp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module brfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/byte_ring_fifo_with_peek_core.sv]
// Top level of the byte ring FIFO with a peek cursor: pointer control and result register.
//
// One operation is taken per clock cycle (busy stays low) and its result appears on the
// result ports in the cycle after acceptance, for one cycle, marked by done; the
// receiver cannot stall it. That delay comes from the registered read of the byte
// store, which is read at the head for pop and at the cursor for peek. Pointers and counts
// live in flip-flops and are updated at the acceptance edge, so back-to-back operations,
// including a pop or peek of a byte pushed the cycle before, need no interlock. Writing
// the queue size empties the queue; write it only while no result is pending. Bytes of
// the store never pushed read as arbitrary values, which no operation sequence exposes.
`default_nettype none
module byte_ring_fifo_with_peek_core #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [2:0]    operation,
  input  wire logic [7:0]    data_in,
  input  wire logic [CW-1:0] peek_offset,
  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_data,
  output logic               done,
  output logic      [1:0]    status,
  output logic      [7:0]    data_out,
  output logic      [CW-1:0] byte_count,
  output logic      [CW-1:0] free_space,
  output logic               is_empty,
  output logic               peek_exhausted,
  output logic      [CW-1:0] peek_position
);

  localparam int RESET_SIZE = (DEPTH < 256) ? DEPTH : 256;

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [AW-1:0] cursor, cursor_next;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] unpeeked, unpeeked_next;
  logic [CW-1:0] qsize, qsize_next;

  logic                  accept;
  logic                  wr_en;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [7:0]            rd_data;
  brfp_pkg::status_t     status_next;
  logic [CW-1:0]         off_clamp;
  logic [CW:0]           off_pos;

  logic              show_data;
  brfp_pkg::status_t status_q;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [CW-1:0] size);
    logic [CW:0] n;
    n = (CW+1)'(idx) + (CW+1)'(1);
    return (n >= {1'b0, size}) ? '0 : AW'(n);
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    cursor_next   = cursor;
    held_next     = held;
    unpeeked_next = unpeeked;
    qsize_next    = qsize;
    status_next   = brfp_pkg::ST_OK;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = head;
    off_clamp     = (peek_offset > held) ? held : peek_offset;
    off_pos       = (CW+1)'(head) + (CW+1)'(off_clamp);
    if (off_pos >= {1'b0, qsize}) begin
      off_pos = off_pos - {1'b0, qsize};
    end
    if (cfg_we) begin
      if (cfg_data == '0) begin
        qsize_next = CW'(1);
      end else if (cfg_data > CW'(DEPTH)) begin
        qsize_next = CW'(DEPTH);
      end else begin
        qsize_next = cfg_data;
      end
      head_next     = '0;
      tail_next     = '0;
      cursor_next   = '0;
      held_next     = '0;
      unpeeked_next = '0;
    end else if (accept) begin
      case (operation)
        brfp_pkg::OP_PUSH: begin
          if (held >= qsize) begin
            status_next = brfp_pkg::ST_FULL;
          end else begin
            wr_en         = 1'b1;
            tail_next     = advance(tail, qsize);
            held_next     = held + CW'(1);
            unpeeked_next = unpeeked + CW'(1);
          end
        end
        brfp_pkg::OP_POP: begin
          if (held == '0) begin
            status_next = brfp_pkg::ST_EMPTY;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = head;
            head_next     = advance(head, qsize);
            cursor_next   = advance(head, qsize);
            held_next     = held - CW'(1);
            unpeeked_next = held - CW'(1);
          end
        end
        brfp_pkg::OP_PEEK: begin
          if (unpeeked == '0) begin
            status_next = brfp_pkg::ST_NO_PEEK;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = cursor;
            cursor_next   = advance(cursor, qsize);
            unpeeked_next = unpeeked - CW'(1);
          end
        end
        brfp_pkg::OP_REWIND: begin
          cursor_next   = head;
          unpeeked_next = held;
        end
        brfp_pkg::OP_COMMIT: begin
          head_next = cursor;
          held_next = unpeeked;
        end
        brfp_pkg::OP_SETOFF: begin
          cursor_next   = AW'(off_pos);
          unpeeked_next = held - off_clamp;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      cursor   <= '0;
      held     <= '0;
      unpeeked <= '0;
      qsize    <= CW'(RESET_SIZE);
      done     <= 1'b0;
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      cursor   <= cursor_next;
      held     <= held_next;
      unpeeked <= unpeeked_next;
      qsize    <= qsize_next;
      done     <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q       <= status_next;
      show_data      <= rd_en;
      byte_count     <= held_next;
      free_space     <= qsize - held_next;
      is_empty       <= (held_next == '0);
      peek_exhausted <= (unpeeked_next == '0);
      peek_position  <= held_next - unpeeked_next;
    end
  end

  assign status   = status_q;
  assign data_out = show_data ? rd_data : 8'd0;

  brfp_ram #(
    .WIDTH (brfp_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (data_in),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held <= qsize && unpeeked <= held)
    else $error("byte count exceeds queue size or unpeeked exceeds count");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted request produced no result");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (byte_count == '0)) && (peek_position <= byte_count))
    else $error("result flags disagree with counts");

  a_full_free: assert property (@(posedge clk) disable iff (rst)
    (done && status == brfp_pkg::ST_FULL) |-> (free_space == '0))
    else $error("full status with free space left");

endmodule
`default_nettype wire

[dv/tb_byte_ring_fifo_with_peek_core.sv]
// Self-checking testbench for the byte ring FIFO with peek cursor core.
module tb_byte_ring_fifo_with_peek_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNDEF = 3'd7;
  localparam int RING_MAX = 256;

  typedef struct packed {
    brfp_pkg::status_t st;
    logic [7:0]        dout;
    logic [8:0]        cnt;
    logic [8:0]        fre;
    logic              emp;
    logic              pex;
    logic [8:0]        pos;
  } fifo_report_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] operation = '0;
  logic [7:0] data_in = '0;
  logic [8:0] peek_offset = '0;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_data = '0;
  logic       busy;
  logic       done;
  logic [1:0] status;
  logic [7:0] data_out;
  logic [8:0] byte_count;
  logic [8:0] free_space;
  logic       is_empty;
  logic       peek_exhausted;
  logic [8:0] peek_position;

  byte_ring_fifo_with_peek_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .data_in       (data_in),
    .peek_offset   (peek_offset),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .data_out      (data_out),
    .byte_count    (byte_count),
    .free_space    (free_space),
    .is_empty      (is_empty),
    .peek_exhausted(peek_exhausted),
    .peek_position (peek_position)
  );

  // FIFO shadow state
  logic [7:0]   ring_model [RING_MAX];
  int           head_idx, tail_idx, cursor_idx;
  int           held_cnt, unpeeked_cnt, model_size;
  fifo_report_t op_results_due[$];

  int  mismatches = 0;
  int  ops_sent = 0;
  int  results_checked = 0;
  int  size_writes = 0;
  bit  idle_en = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int wrap_next(input int idx);
    return (idx + 1 >= model_size) ? 0 : idx + 1;
  endfunction

  function automatic void clear_pointers();
    head_idx = 0;
    tail_idx = 0;
    cursor_idx = 0;
    held_cnt = 0;
    unpeeked_cnt = 0;
  endfunction

  function automatic void apply_size(input logic [8:0] v);
    if (v == 0) model_size = 1;
    else if (v > RING_MAX) model_size = RING_MAX;
    else model_size = int'(v);
    clear_pointers();
  endfunction

  function automatic fifo_report_t fifo_step(input logic [2:0] op, input logic [7:0] din,
                                             input logic [8:0] off);
    fifo_report_t r;
    int d;
    int p;
    r = '0;
    r.st = brfp_pkg::ST_OK;
    case (op)
      brfp_pkg::OP_PUSH: begin
        if (held_cnt >= model_size) begin
          r.st = brfp_pkg::ST_FULL;
        end else begin
          ring_model[tail_idx] = din;
          tail_idx = wrap_next(tail_idx);
          held_cnt++;
          unpeeked_cnt++;
        end
      end
      brfp_pkg::OP_POP: begin
        if (held_cnt == 0) begin
          r.st = brfp_pkg::ST_EMPTY;
        end else begin
          r.dout = ring_model[head_idx];
          head_idx = wrap_next(head_idx);
          held_cnt--;
          cursor_idx = head_idx;
          unpeeked_cnt = held_cnt;
        end
      end
      brfp_pkg::OP_PEEK: begin
        if (unpeeked_cnt == 0) begin
          r.st = brfp_pkg::ST_NO_PEEK;
        end else begin
          r.dout = ring_model[cursor_idx];
          cursor_idx = wrap_next(cursor_idx);
          unpeeked_cnt--;
        end
      end
      brfp_pkg::OP_REWIND: begin
        cursor_idx = head_idx;
        unpeeked_cnt = held_cnt;
      end
      brfp_pkg::OP_COMMIT: begin
        head_idx = cursor_idx;
        held_cnt = unpeeked_cnt;
      end
      brfp_pkg::OP_SETOFF: begin
        d = (off > held_cnt) ? held_cnt : int'(off);
        p = head_idx + d;
        if (p >= model_size) p -= model_size;
        cursor_idx = p;
        unpeeked_cnt = held_cnt - d;
      end
      default: ;
    endcase
    r.cnt = 9'(held_cnt);
    r.fre = 9'(model_size - held_cnt);
    r.emp = (held_cnt == 0);
    r.pex = (unpeeked_cnt == 0);
    r.pos = 9'(held_cnt - unpeeked_cnt);
    return r;
  endfunction

  task automatic check_report(input fifo_report_t got);
    fifo_report_t want;
    if (op_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with no request pending: st=%0d dout=%h cnt=%0d", $time,
                 got.st, got.dout, got.cnt);
    end else begin
      want = op_results_due.pop_front();
      results_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch st %0d/%0d dout %h/%h cnt %0d/%0d free %0d/%0d ",
                    "empty %b/%b exhausted %b/%b pos %0d/%0d (expected/actual)"},
                   $time, want.st, got.st, want.dout, got.dout, want.cnt, got.cnt,
                   want.fre, got.fre, want.emp, got.emp, want.pex, got.pex,
                   want.pos, got.pos);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      model_size = RING_MAX;
      clear_pointers();
      op_results_due.delete();
    end else begin
      if (done)
        check_report({brfp_pkg::status_t'(status), data_out, byte_count, free_space,
                      is_empty, peek_exhausted, peek_position});
      if (cfg_we) apply_size(cfg_data);
      if (start && !busy) op_results_due.push_back(fifo_step(operation, data_in, peek_offset));
    end
  end

  task automatic issue(input logic [2:0] op, input logic [7:0] din, input logic [8:0] off);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    operation = op;
    data_in = din;
    peek_offset = off;
    @(posedge clk);
    while (busy) @(posedge clk);
    ops_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (op_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_queue_size(input logic [8:0] v);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    size_writes++;
  endtask

  task automatic rand_op(input int push_pct);
    logic [2:0] op;
    logic [8:0] off;
    int r;
    r = $urandom_range(0, 19);
    if ($urandom_range(0, 99) < push_pct) op = brfp_pkg::OP_PUSH;
    else if (r < 6) op = brfp_pkg::OP_POP;
    else if (r < 12) op = brfp_pkg::OP_PEEK;
    else if (r < 14) op = brfp_pkg::OP_REWIND;
    else if (r < 16) op = brfp_pkg::OP_COMMIT;
    else if (r < 18) op = brfp_pkg::OP_SETOFF;
    else if (r < 19) op = brfp_pkg::OP_STATUS;
    else op = OP_UNDEF;
    if ($urandom_range(0, 3) == 0) off = 9'($urandom_range(0, 511));
    else off = 9'($urandom_range(0, held_cnt + 1));
    issue(op, 8'($urandom), off);
  endtask

  task automatic test_reset_edges();
    issue(brfp_pkg::OP_STATUS, 8'h00, 9'h000);
    issue(brfp_pkg::OP_POP, 8'hFF, 9'h000);
    issue(brfp_pkg::OP_PEEK, 8'h00, 9'h000);
    issue(OP_UNDEF, 8'hFF, 9'h1FF);
    issue(brfp_pkg::OP_SETOFF, 8'h00, 9'h1FF);
    issue(brfp_pkg::OP_COMMIT, 8'h00, 9'h000);
    issue(brfp_pkg::OP_REWIND, 8'h00, 9'h000);
    issue(brfp_pkg::OP_PUSH, 8'h00, 9'h000);
    issue(brfp_pkg::OP_PUSH, 8'hFF, 9'h1FF);
    issue(brfp_pkg::OP_PUSH, 8'hA5, 9'h000);
    issue(brfp_pkg::OP_PUSH, 8'h5A, 9'h000);
    issue(brfp_pkg::OP_PEEK, 8'h00, 9'h000);
    issue(brfp_pkg::OP_PEEK, 8'h00, 9'h000);
    issue(brfp_pkg::OP_REWIND, 8'h00, 9'h000);
    issue(brfp_pkg::OP_SETOFF, 8'h00, 9'h100);
    issue(brfp_pkg::OP_PEEK, 8'h00, 9'h000);
    issue(brfp_pkg::OP_SETOFF, 8'h00, 9'h002);
    issue(brfp_pkg::OP_PEEK, 8'h00, 9'h000);
    issue(brfp_pkg::OP_COMMIT, 8'h00, 9'h000);
    issue(brfp_pkg::OP_POP, 8'h00, 9'h000);
    issue(brfp_pkg::OP_POP, 8'h00, 9'h000);
  endtask

  task automatic test_tiny_queue();
    set_queue_size(9'h000);
    issue(brfp_pkg::OP_PUSH, 8'h3C, 9'h000);
    issue(brfp_pkg::OP_PUSH, 8'hC3, 9'h000);
    issue(brfp_pkg::OP_PEEK, 8'h00, 9'h000);
    issue(brfp_pkg::OP_PEEK, 8'h00, 9'h000);
    issue(brfp_pkg::OP_COMMIT, 8'h00, 9'h000);
    issue(brfp_pkg::OP_POP, 8'h00, 9'h000);
  endtask

  task automatic test_fill_to_depth();
    set_queue_size(9'h1FF);
    while (held_cnt < RING_MAX) rand_op(85);
    issue(brfp_pkg::OP_PUSH, 8'h81, 9'h000);
    issue(brfp_pkg::OP_PUSH, 8'h7E, 9'h000);
    issue(brfp_pkg::OP_REWIND, 8'h00, 9'h000);
    issue(brfp_pkg::OP_SETOFF, 8'h00, 9'h100);
    issue(brfp_pkg::OP_PEEK, 8'h00, 9'h000);
    issue(brfp_pkg::OP_SETOFF, 8'h00, 9'h0FF);
    issue(brfp_pkg::OP_PEEK, 8'h00, 9'h000);
    issue(brfp_pkg::OP_COMMIT, 8'h00, 9'h000);
    repeat (30) rand_op(40);
  endtask

  task automatic test_random_sizes();
    logic [8:0] sizes [7];
    sizes = '{9'd1, 9'd2, 9'd3, 9'd5, 9'd17, 9'd64, 9'd256};
    foreach (sizes[i]) begin
      set_queue_size(sizes[i]);
      repeat (50) rand_op(50);
    end
  endtask

  task automatic test_back_to_back();
    set_queue_size(9'd4);
    idle_en = 1'b0;
    repeat (60) rand_op(45);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_edges();
    test_tiny_queue();
    test_fill_to_depth();
    test_random_sizes();
    test_back_to_back();
    drain();
    repeat (3) @(posedge clk);
    $display("%0d operations over %0d queue-size settings, sizes 1 to 256, incl. full/wrap",
             ops_sent, size_writes + 1);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && op_results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
